@@ rtl/pn2d_pkg.sv @@
// Shared constants, types and arithmetic helpers for the 2D noise pipeline.
package pn2d_pkg;

    // Number format and table geometry (table size must be a power of two)
    localparam int FRAC_BITS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);

    // Request and result field widths
    localparam int ACT_W    = 1;
    localparam int IDX_W    = 8;
    localparam int PERM_W   = 8;
    localparam int COORD_W  = 24;
    localparam int NOISE_W  = 18;
    localparam int BYTE_W   = 8;

    // Field positions inside the stream data words
    localparam int IDX_LSB  = 0;
    localparam int VAL_LSB  = IDX_LSB + IDX_W;
    localparam int X_LSB    = VAL_LSB + PERM_W;
    localparam int Y_LSB    = X_LSB + COORD_W;
    localparam int S_DATA_W = ((Y_LSB + COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((NOISE_W + BYTE_W + 7) / 8) * 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
    localparam logic [ACT_W-1:0] ACT_EVAL  = 1'b1;

    // Gradient select codes (low two hash bits)
    localparam logic [1:0] GRAD_PP = 2'd0;   // dx + dy
    localparam logic [1:0] GRAD_NP = 2'd1;   // -dx + dy
    localparam logic [1:0] GRAD_NN = 2'd2;   // -dx - dy
    localparam logic [1:0] GRAD_PN = 2'd3;   // dx - dy

    // Internal widths
    localparam int RW      = 64;
    localparam int ONE     = 2 ** FRAC_BITS;
    localparam int FADE_W  = FRAC_BITS + 1;
    localparam int GRAD_W  = FRAC_BITS + 3;
    localparam int LERP_W  = FRAC_BITS + 4;

    // Quintic fade coefficients 6t^5 - 15t^4 + 10t^3
    localparam int FADE_C5 = 6;
    localparam int FADE_C4 = 15;
    localparam int FADE_C3 = 10;

    // Output conversion
    localparam int OUT_FRAC = 16;
    localparam int SH_DN    = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int SH_UP    = (FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int N16_ONE  = 2 ** OUT_FRAC;
    localparam int BYTE_MAX = 2 ** BYTE_W - 1;
    localparam int BYTE_SH  = OUT_FRAC + 1;
    localparam int BYTE_RND = 2 ** (BYTE_SH - 1);
    localparam logic signed [RW-1:0] NOISE_MAX = RW'(2 ** (NOISE_W - 1) - 1);
    localparam logic signed [RW-1:0] NOISE_MIN = -RW'(2 ** (NOISE_W - 1));

    // Pipeline stages
    localparam int ST_IN   = 0;   // request register
    localparam int ST_HX   = 1;   // column hashes, fade products
    localparam int ST_HC   = 2;   // corner hashes, fade cube
    localparam int ST_GRAD = 3;   // corner gradients, fade done
    localparam int ST_LY   = 4;   // vertical blend products
    localparam int ST_LYS  = 5;   // vertical blend sums
    localparam int ST_LX   = 6;   // horizontal blend product
    localparam int ST_NRM  = 7;   // Q.16 noise, saturated
    localparam int ST_OUT  = 8;   // result register
    localparam int NUM_STG = 9;

    typedef logic [NUM_STG-1:0] stg_en_t;

    // floor((p + half) / 2^s) for signed p
    function automatic logic signed [RW-1:0] rnd_shift(input logic signed [RW-1:0] p,
                                                       input int unsigned s);
        logic signed [RW-1:0] half;
        half = '0;
        if (s != 0)
            half[s-1] = 1'b1;
        return (p + half) >>> s;
    endfunction

    // Wrap any index into the table
    function automatic logic [TBL_AW-1:0] to_addr(input logic [31:0] v);
        return v[TBL_AW-1:0];
    endfunction

    // Diagonal gradient dot product
    function automatic logic signed [GRAD_W-1:0] grad(input logic [1:0] h,
                                                      input logic signed [GRAD_W-1:0] dx,
                                                      input logic signed [GRAD_W-1:0] dy);
        logic signed [GRAD_W-1:0] g;
        unique case (h)
            GRAD_PP: g = dx + dy;
            GRAD_NP: g = dy - dx;
            GRAD_NN: g = -dx - dy;
            GRAD_PN: g = dx - dy;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/perlin_noise_2d.sv @@
// An evaluate passes every stage in order from request register to result register.
// Throughput: one request per cycle; table reads use three RAM copies with two read
// ports each, so the six reads of one evaluate fit in a single pass of the pipeline.
// Write requests update the table in pipeline order and produce no result.
// Reset clears the stage valid bits only; table entries are undefined until written.
// A held result stalls the stages behind it; bubbles still close up, so intake stops
// only once every stage holds a request.
module perlin_noise_2d (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // from bit 0: table_index[7:0], table_value[7:0], x_coord[23:0], y_coord[23:0]
    input  logic [pn2d_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // action (0 = table write, 1 = evaluate)
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // from bit 0: noise_value[17:0], noise_byte[7:0], zero pad
    output logic [pn2d_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import pn2d_pkg::*;

    // Stage handshake
    stg_en_t                en;
    logic [NUM_STG-1:0]     valid_reg, valid_next;

    // Stage 0: request register
    logic [ACT_W-1:0]       act0_reg;
    logic [IDX_W-1:0]       idx0_reg;
    logic [PERM_W-1:0]      val0_reg;
    logic [COORD_W-1:0]     x0_reg, y0_reg;

    // Stage 1: column hashes in flight
    logic                   eval1_reg;
    logic [IDX_W-1:0]       idx1_reg;
    logic [PERM_W-1:0]      val1_reg;
    logic [TBL_AW-1:0]      ycell1_reg;
    logic [FRAC_BITS-1:0]   xf1_reg, yf1_reg;

    // Stage 2: corner hashes in flight
    logic                   eval2_reg;
    logic [FRAC_BITS-1:0]   xf2_reg, yf2_reg;

    // Table ports
    logic                   we0, we12;
    logic [TBL_AW-1:0]      xcell0, waddr0, waddr12;
    logic [PERM_W-1:0]      hx0, hx1, h00, h01, h10, h11;
    logic [FADE_W-1:0]      u, v;
    logic signed [NOISE_W-1:0] noise_value;
    logic [BYTE_W-1:0]      noise_byte;

    // A stage loads when it is empty or its content moves on; walk back from the output.
    always_comb
    begin
        en[ST_OUT] = !valid_reg[ST_OUT] || m_axis_tready;
        for (int i = NUM_STG - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];

        valid_next[ST_IN] = s_axis_tvalid;
        for (int i = 1; i < NUM_STG; i++)
            valid_next[i] = valid_reg[i-1];
        // drop table writes once every RAM copy has seen them
        valid_next[ST_GRAD] = valid_reg[ST_HC] && eval2_reg;
    end

    assign s_axis_tready = en[ST_IN];
    assign m_axis_tvalid = valid_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= (valid_reg & ~en) | (valid_next & en);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            act0_reg <= s_axis_tuser;
            idx0_reg <= s_axis_tdata[IDX_LSB +: IDX_W];
            val0_reg <= s_axis_tdata[VAL_LSB +: PERM_W];
            x0_reg   <= s_axis_tdata[X_LSB +: COORD_W];
            y0_reg   <= s_axis_tdata[Y_LSB +: COORD_W];
        end
        if (en[ST_HX])
        begin
            eval1_reg  <= (act0_reg == ACT_EVAL);
            idx1_reg   <= idx0_reg;
            val1_reg   <= val0_reg;
            ycell1_reg <= to_addr(32'(y0_reg >> FRAC_BITS));
            xf1_reg    <= x0_reg[FRAC_BITS-1:0];
            yf1_reg    <= y0_reg[FRAC_BITS-1:0];
        end
        if (en[ST_HC])
        begin
            eval2_reg <= eval1_reg;
            xf2_reg   <= xf1_reg;
            yf2_reg   <= yf1_reg;
        end
    end

    // Copy 0: column hashes. Write it as the request leaves stage 0 so that every
    // copy sees writes and reads in request order.
    assign xcell0 = to_addr(32'(x0_reg >> FRAC_BITS));
    assign waddr0 = to_addr(32'(idx0_reg));
    assign we0    = en[ST_HX] && valid_reg[ST_IN] && (act0_reg == ACT_WRITE);

    pn2d_ram #(
        .DATA_W (PERM_W),
        .DEPTH  (TABLE_SIZE)
    ) u_ram_col (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (val0_reg),
        .re      (en[ST_HX]),
        .raddr_a (xcell0),
        .raddr_b (to_addr(32'(x0_reg >> FRAC_BITS) + 32'd1)),
        .rdata_a (hx0),
        .rdata_b (hx1)
    );

    // Copies 1 and 2: corner hashes, written as the request leaves stage 1
    assign waddr12 = to_addr(32'(idx1_reg));
    assign we12    = en[ST_HC] && valid_reg[ST_HX] && !eval1_reg;

    pn2d_ram #(
        .DATA_W (PERM_W),
        .DEPTH  (TABLE_SIZE)
    ) u_ram_left (
        .clk     (clk),
        .we      (we12),
        .waddr   (waddr12),
        .wdata   (val1_reg),
        .re      (en[ST_HC]),
        .raddr_a (to_addr(32'(hx0) + 32'(ycell1_reg))),
        .raddr_b (to_addr(32'(hx0) + 32'(ycell1_reg) + 32'd1)),
        .rdata_a (h00),
        .rdata_b (h01)
    );

    pn2d_ram #(
        .DATA_W (PERM_W),
        .DEPTH  (TABLE_SIZE)
    ) u_ram_right (
        .clk     (clk),
        .we      (we12),
        .waddr   (waddr12),
        .wdata   (val1_reg),
        .re      (en[ST_HC]),
        .raddr_a (to_addr(32'(hx1) + 32'(ycell1_reg))),
        .raddr_b (to_addr(32'(hx1) + 32'(ycell1_reg) + 32'd1)),
        .rdata_a (h10),
        .rdata_b (h11)
    );

    // Fade weights run alongside the hashing, ready at stage 3
    pn2d_fade u_fade_x (
        .clk  (clk),
        .en   (en),
        .t_in (x0_reg[FRAC_BITS-1:0]),
        .fade (u)
    );

    pn2d_fade u_fade_y (
        .clk  (clk),
        .en   (en),
        .t_in (y0_reg[FRAC_BITS-1:0]),
        .fade (v)
    );

    // Gradients, blend and output formatting
    pn2d_blend u_blend (
        .clk         (clk),
        .en          (en),
        .h00         (h00),
        .h01         (h01),
        .h10         (h10),
        .h11         (h11),
        .xf          (xf2_reg),
        .yf          (yf2_reg),
        .u           (u),
        .v           (v),
        .noise_value (noise_value),
        .noise_byte  (noise_byte)
    );

    assign m_axis_tdata = M_DATA_W'({noise_byte, noise_value});

endmodule

@@ rtl/pn2d_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module pn2d_ram #(
    parameter  int DATA_W = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ rtl/pn2d_fade.sv @@
// Three-stage quintic fade unit: ((6t-15)t+10) * t^3 with rounded products.
module pn2d_fade (
    input  logic                           clk,
    input  pn2d_pkg::stg_en_t              en,
    input  logic [pn2d_pkg::FRAC_BITS-1:0] t_in,
    output logic [pn2d_pkg::FADE_W-1:0]    fade
);
    import pn2d_pkg::*;

    localparam int AW  = FRAC_BITS + 5;
    localparam int P1W = AW + FRAC_BITS + 1;
    localparam int TTW = 2 * FRAC_BITS;
    localparam int BW  = FRAC_BITS + 5;
    localparam int P3W = BW + FRAC_BITS + 1;
    localparam logic signed [AW-1:0] A_OFS = AW'(FADE_C4 * ONE);
    localparam logic signed [BW-1:0] B_OFS = BW'(FADE_C3 * ONE);

    logic signed [AW-1:0]      t_s;
    logic signed [AW-1:0]      a_s;
    logic signed [P1W-1:0]     at_next, at_reg;
    logic [TTW-1:0]            tt_next, tt_reg;
    logic [FRAC_BITS-1:0]      t1_reg;
    logic signed [BW-1:0]      b_next, b_reg;
    logic [FRAC_BITS-1:0]      t2;
    logic [TTW-1:0]            t3p_next, t3p_reg;
    logic [FRAC_BITS-1:0]      t3;
    logic signed [P3W-1:0]     fp;
    logic [FADE_W-1:0]         fade_next, fade_reg;

    always_comb
    begin
        // first products: (6t - 15) * t and t * t
        t_s     = signed'(AW'(t_in));
        a_s     = t_s * AW'(FADE_C5) - A_OFS;
        at_next = P1W'(a_s) * P1W'(t_s);
        tt_next = TTW'(t_in) * TTW'(t_in);

        // polynomial term and t^3
        b_next   = BW'(rnd_shift(RW'(at_reg), FRAC_BITS)) + B_OFS;
        t2       = FRAC_BITS'(rnd_shift(RW'(tt_reg), FRAC_BITS));
        t3p_next = TTW'(t2) * TTW'(t1_reg);

        // final product
        t3        = FRAC_BITS'(rnd_shift(RW'(t3p_reg), FRAC_BITS));
        fp        = P3W'(b_reg) * P3W'(signed'({1'b0, t3}));
        fade_next = FADE_W'(rnd_shift(RW'(fp), FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_HX])
        begin
            at_reg <= at_next;
            tt_reg <= tt_next;
            t1_reg <= t_in;
        end
        if (en[ST_HC])
        begin
            b_reg   <= b_next;
            t3p_reg <= t3p_next;
        end
        if (en[ST_GRAD])
        begin
            fade_reg <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

@@ rtl/pn2d_blend.sv @@
// Gradient, bilinear blend and output conversion stages of the noise pipeline.
module pn2d_blend (
    input  logic                                clk,
    input  pn2d_pkg::stg_en_t                   en,
    input  logic [pn2d_pkg::PERM_W-1:0]         h00,
    input  logic [pn2d_pkg::PERM_W-1:0]         h01,
    input  logic [pn2d_pkg::PERM_W-1:0]         h10,
    input  logic [pn2d_pkg::PERM_W-1:0]         h11,
    input  logic [pn2d_pkg::FRAC_BITS-1:0]      xf,
    input  logic [pn2d_pkg::FRAC_BITS-1:0]      yf,
    input  logic [pn2d_pkg::FADE_W-1:0]         u,
    input  logic [pn2d_pkg::FADE_W-1:0]         v,
    output logic signed [pn2d_pkg::NOISE_W-1:0] noise_value,
    output logic [pn2d_pkg::BYTE_W-1:0]         noise_byte
);
    import pn2d_pkg::*;

    localparam int DFW = GRAD_W + 1;
    localparam int VW  = FADE_W + 1;
    localparam int P0W = DFW + VW;
    localparam int LDW = LERP_W + 1;
    localparam int P1W = LDW + VW;
    localparam int SW  = NOISE_W + 1;
    localparam int BPW = NOISE_W + BYTE_W + 1;
    localparam logic signed [GRAD_W-1:0] G_ONE = GRAD_W'(ONE);

    logic signed [GRAD_W-1:0] dx0, dy0, dx1, dy1;
    logic signed [GRAD_W-1:0] bl_next, tl_next, br_next, tr_next;
    logic signed [GRAD_W-1:0] bl_reg, tl_reg, br_reg, tr_reg;
    logic signed [VW-1:0]     v_s, u_s;
    logic signed [DFW-1:0]    d0, d1;
    logic signed [P0W-1:0]    p0_next, p1_next, p0_reg, p1_reg;
    logic signed [GRAD_W-1:0] bl4_reg, br4_reg;
    logic [FADE_W-1:0]        u4_reg, u5_reg;
    logic signed [LERP_W-1:0] l0_next, l1_next, l0_reg, l1_reg, l0_6_reg;
    logic signed [LDW-1:0]    dl;
    logic signed [P1W-1:0]    pf_next, pf_reg;
    logic signed [RW-1:0]     nf, n16w;
    logic signed [NOISE_W-1:0] n16_next, n16_reg;
    logic signed [SW-1:0]     s_w;
    logic [NOISE_W-1:0]       sp;
    logic [BPW-1:0]           bp, bq;
    logic [BYTE_W-1:0]        byte_next;
    logic signed [NOISE_W-1:0] noise_value_reg;
    logic [BYTE_W-1:0]        noise_byte_reg;

    always_comb
    begin
        // corner offsets and gradients
        dx0     = signed'(GRAD_W'(xf));
        dy0     = signed'(GRAD_W'(yf));
        dx1     = dx0 - G_ONE;
        dy1     = dy0 - G_ONE;
        bl_next = grad(h00[1:0], dx0, dy0);
        tl_next = grad(h01[1:0], dx0, dy1);
        br_next = grad(h10[1:0], dx1, dy0);
        tr_next = grad(h11[1:0], dx1, dy1);

        // blend along y: products
        v_s     = signed'(VW'(v));
        d0      = DFW'(tl_reg) - DFW'(bl_reg);
        d1      = DFW'(tr_reg) - DFW'(br_reg);
        p0_next = P0W'(d0) * P0W'(v_s);
        p1_next = P0W'(d1) * P0W'(v_s);

        // blend along y: sums
        l0_next = LERP_W'(RW'(bl4_reg) + rnd_shift(RW'(p0_reg), FRAC_BITS));
        l1_next = LERP_W'(RW'(br4_reg) + rnd_shift(RW'(p1_reg), FRAC_BITS));

        // blend along x: product
        u_s     = signed'(VW'(u5_reg));
        dl      = LDW'(l1_reg) - LDW'(l0_reg);
        pf_next = P1W'(dl) * P1W'(u_s);

        // finish blend, convert to Q.16 and saturate
        nf   = RW'(l0_6_reg) + rnd_shift(RW'(pf_reg), FRAC_BITS);
        n16w = rnd_shift(nf, SH_DN) <<< SH_UP;
        if (n16w > NOISE_MAX)
            n16_next = NOISE_W'(NOISE_MAX);
        else if (n16w < NOISE_MIN)
            n16_next = NOISE_W'(NOISE_MIN);
        else
            n16_next = NOISE_W'(n16w);

        // byte: round(255 * (n + 1) / 2), saturated
        s_w = SW'(n16_reg) + SW'(N16_ONE);
        sp  = (s_w < 0) ? '0 : NOISE_W'(s_w);
        bp  = BPW'(sp) * BPW'(BYTE_MAX) + BPW'(BYTE_RND);
        bq  = bp >> BYTE_SH;
        byte_next = (bq > BPW'(BYTE_MAX)) ? BYTE_W'(BYTE_MAX) : BYTE_W'(bq);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_GRAD])
        begin
            bl_reg <= bl_next;
            tl_reg <= tl_next;
            br_reg <= br_next;
            tr_reg <= tr_next;
        end
        if (en[ST_LY])
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            bl4_reg <= bl_reg;
            br4_reg <= br_reg;
            u4_reg  <= u;
        end
        if (en[ST_LYS])
        begin
            l0_reg <= l0_next;
            l1_reg <= l1_next;
            u5_reg <= u4_reg;
        end
        if (en[ST_LX])
        begin
            pf_reg   <= pf_next;
            l0_6_reg <= l0_reg;
        end
        if (en[ST_NRM])
        begin
            n16_reg <= n16_next;
        end
        if (en[ST_OUT])
        begin
            noise_value_reg <= n16_reg;
            noise_byte_reg  <= byte_next;
        end
    end

    assign noise_value = noise_value_reg;
    assign noise_byte  = noise_byte_reg;

endmodule
